[src/particle_table_update_assert.svh]
// assertion macros for the particle table
// used by the rtl file that checks its own control logic; needs aclk and aresetn in scope
`ifndef PARTICLE_TABLE_UPDATE_ASSERT_SVH
`define PARTICLE_TABLE_UPDATE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define PTU_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("particle table check failed");

// condition that holds in the cycle after the trigger
`define PTU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("particle table check failed");

`endif

[src/ptu_pkg.sv]
// shared types and constants of the particle table
// no dependencies
`default_nettype none

package ptu_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int SURV_W  = 7;
    localparam int MS_W    = 31;
    localparam int DT_W    = 16;
    localparam int LIFE_W  = 24;
    localparam int WORD_W  = 32;

    // actions of an input beat
    localparam logic ACT_SPAWN = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // configuration register indexes
    localparam logic REG_MAX_SPEED  = 1'b0;
    localparam logic REG_GRAVITY_ON = 1'b1;

    // one table entry as held in the ram
    typedef struct packed {
        logic [LIFE_W-1:0] life;
        logic [WORD_W-1:0] vel_x;
        logic [WORD_W-1:0] vel_y;
        logic [WORD_W-1:0] vel_z;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] tint;
    } particle_t;

    localparam int ENTRY_W = $bits(particle_t);

    // per-tick controls handed to the update pipeline
    typedef struct packed {
        logic [DT_W-1:0] dt;
        logic [MS_W-1:0] gstep;
        logic [MS_W-1:0] max_speed;
        logic            grav_on;
    } step_ctrl_t;

endpackage

`default_nettype wire

[src/particle_table_update.sv]
// Particle table with spawn and tick beats. A spawn beat appends a particle unless the table
// holds MAX_PARTICLES already. A tick beat first runs an update pass that reads every live
// entry from the table ram once, one per cycle, through a three-stage update pipeline and
// writes survivors back compacted. An emit pass then reads the survivors back in table order
// and sends one result beat per survivor, one per cycle while m_ready stays high. The single
// read port of the table ram sets both passes. The last result may still wait on m_ready
// while the next beat is taken. The table needs no clearing after reset.
// depends on ptu_pkg, ptu_ram, ptu_step and particle_table_update_assert.svh
`default_nettype none

`include "particle_table_update_assert.svh"

module particle_table_update
    import ptu_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input beats
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_action,
    input  wire logic [DT_W-1:0]           s_delta_time,
    input  wire logic signed [WORD_W-1:0]  s_start_x,
    input  wire logic signed [WORD_W-1:0]  s_start_y,
    input  wire logic signed [WORD_W-1:0]  s_start_z,
    input  wire logic signed [WORD_W-1:0]  s_speed_x,
    input  wire logic signed [WORD_W-1:0]  s_speed_y,
    input  wire logic signed [WORD_W-1:0]  s_speed_z,
    input  wire logic [LIFE_W-1:0]         s_lifetime,
    input  wire logic [WORD_W-1:0]         s_tint,
    // result beats
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [WORD_W-1:0]       m_out_x,
    output logic signed [WORD_W-1:0]       m_out_y,
    output logic signed [WORD_W-1:0]       m_out_z,
    output logic [WORD_W-1:0]              m_out_tint,
    output logic                           m_final_res,
    output logic [SURV_W-1:0]              m_survivors,
    // configuration writes
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [MS_W-1:0]           cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  live_cnt_reg;
    logic [CNT_W-1:0]  live_cnt_next;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  rd_idx_next;
    logic [CNT_W-1:0]  rd_idx_inc;
    logic [CNT_W-1:0]  wr_idx_reg;
    logic [CNT_W-1:0]  wr_idx_next;
    logic              rd_pend_reg;
    logic              rd_pend_next;
    logic [DT_W-1:0]   dt_reg;
    logic [MS_W-1:0]   gstep_reg;
    logic [MS_W-1:0]   max_speed_reg;
    logic              grav_on_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              out_load;
    logic              out_free;
    logic              in_beat;
    logic              spawn_drop;
    logic              upd_issue;
    logic [MS_W+DT_W-1:0] gstep_full;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    particle_t         ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    particle_t         ram_rdata;
    particle_t         spawn_ent;

    step_ctrl_t        step_ctrl;
    logic              step_valid;
    particle_t         step_ent;
    logic              step_busy;

    ptu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign step_ctrl = '{dt: dt_reg, gstep: gstep_reg, max_speed: max_speed_reg,
                         grav_on: grav_on_reg};

    ptu_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (step_ctrl),
        .in_valid  (rd_pend_reg),
        .in_entry  (ram_rdata),
        .out_valid (step_valid),
        .out_entry (step_ent),
        .busy      (step_busy)
    );

    // spawn entry from the input beat
    assign spawn_ent = '{life: s_lifetime, vel_x: s_speed_x, vel_y: s_speed_y,
                         vel_z: s_speed_z, pos_x: s_start_x, pos_y: s_start_y,
                         pos_z: s_start_z, tint: s_tint};

    assign s_ready    = (state_reg == S_IDLE);
    assign in_beat    = s_valid && s_ready;
    assign spawn_drop = in_beat && (s_action == ACT_SPAWN) && (live_cnt_reg == CNT_MAX);
    assign out_free   = !m_valid_reg || m_ready;
    assign rd_idx_inc = rd_idx_reg + 1'b1;
    assign upd_issue  = (state_reg == S_UPD) && (rd_idx_reg < live_cnt_reg);
    assign gstep_full = max_speed_reg * s_delta_time;

    // sequencer: spawn, update pass, emit pass
    always_comb begin
        state_next    = state_reg;
        live_cnt_next = live_cnt_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        rd_pend_next  = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = wr_idx_reg[IDX_W-1:0];
        ram_wdata     = step_ent;
        ram_re        = 1'b0;
        ram_raddr     = rd_idx_reg[IDX_W-1:0];
        out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    if (s_action == ACT_TICK) begin
                        state_next  = S_UPD;
                        rd_idx_next = '0;
                        wr_idx_next = '0;
                    end else if (live_cnt_reg < CNT_MAX) begin
                        ram_we        = 1'b1;
                        ram_waddr     = live_cnt_reg[IDX_W-1:0];
                        ram_wdata     = spawn_ent;
                        live_cnt_next = live_cnt_reg + 1'b1;
                    end
                end
            end
            S_UPD: begin
                // survivors come back compacted at the write index
                if (step_valid) begin
                    ram_we      = 1'b1;
                    wr_idx_next = wr_idx_reg + 1'b1;
                end
                if (upd_issue) begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = rd_idx_inc;
                end else if (!rd_pend_reg && !step_busy && !step_valid) begin
                    live_cnt_next = wr_idx_reg;
                    rd_idx_next   = '0;
                    if (wr_idx_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_EMIT;
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                    end
                end
            end
            S_EMIT: begin
                // read data of rd_idx is waiting; fetch the next one as it leaves
                if (out_free) begin
                    out_load = 1'b1;
                    if (rd_idx_inc == live_cnt_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_inc;
                        ram_re      = 1'b1;
                        ram_raddr   = rd_idx_inc[IDX_W-1:0];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        priority if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            live_cnt_reg <= '0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            live_cnt_reg <= live_cnt_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= MS_W'(65536);
            grav_on_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_SPEED:  max_speed_reg <= cfg_wdata;
                REG_GRAVITY_ON: grav_on_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // per-tick delta time and gravity step
    always_ff @(posedge aclk) begin
        if (in_beat && s_action == ACT_TICK) begin
            dt_reg    <= s_delta_time;
            gstep_reg <= gstep_full[MS_W+DT_W-1:DT_W];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_x     <= ram_rdata.pos_x;
            m_out_y     <= ram_rdata.pos_y;
            m_out_z     <= ram_rdata.pos_z;
            m_out_tint  <= ram_rdata.tint;
            m_final_res <= (rd_idx_inc == live_cnt_reg);
            m_survivors <= SURV_W'(live_cnt_reg);
        end
    end

    assign m_valid = m_valid_reg;

    // checks
    `PTU_ASSERT(a_count_bound, live_cnt_reg <= CNT_MAX)
    `PTU_ASSERT(a_compact_order, (state_reg != S_UPD) || (wr_idx_reg <= rd_idx_reg))
    `PTU_ASSERT_NEXT(a_full_drop, spawn_drop, live_cnt_reg == CNT_MAX)
    `PTU_ASSERT(a_emit_in_range, (state_reg != S_EMIT) || (rd_idx_reg < live_cnt_reg))

endmodule

`default_nettype wire

[src/ptu_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module ptu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/ptu_step.sv]
// update pipeline for one particle: life, gravity, euler step with saturation
// depends on ptu_pkg
`default_nettype none

module ptu_step
    import ptu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire step_ctrl_t ctrl,
    input  wire logic       in_valid,
    input  wire particle_t  in_entry,
    output logic            out_valid,
    output particle_t       out_entry,
    output logic            busy
);

    localparam int PROD_W = WORD_W + DT_W + 1;

    logic                     life_ok;
    logic [LIFE_W-1:0]        life_new;
    logic [WORD_W:0]          vy_ext;
    logic [WORD_W:0]          vy_lim;
    logic [WORD_W:0]          vy_diff;
    logic                     vy_above;
    logic [WORD_W-1:0]        vy_grav;
    logic [WORD_W-1:0]        vy_new;

    logic                     s2_valid_reg;
    logic                     s2_valid_next;
    particle_t                s2_ent_reg;
    particle_t                s2_ent_next;
    logic                     s3_valid_reg;
    particle_t                s3_ent_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;

    // position plus floor(v*dt), clamped to the signed 32-bit range
    function automatic logic [WORD_W-1:0] add_sat(input logic [WORD_W-1:0] p,
                                                  input logic [PROD_W-1:0] prod);
        logic [WORD_W+1:0] sum;
        sum = {{2{p[WORD_W-1]}}, p} + {prod[PROD_W-1], prod[PROD_W-1:DT_W]};
        if (sum[WORD_W+1:WORD_W-1] == 3'b000 || sum[WORD_W+1:WORD_W-1] == 3'b111) begin
            add_sat = sum[WORD_W-1:0];
        end else if (sum[WORD_W+1]) begin
            add_sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            add_sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

    // life check and gravity on the raw entry
    always_comb begin
        life_ok  = in_entry.life > {{(LIFE_W-DT_W){1'b0}}, ctrl.dt};
        life_new = in_entry.life - {{(LIFE_W-DT_W){1'b0}}, ctrl.dt};
        vy_ext   = {in_entry.vel_y[WORD_W-1], in_entry.vel_y};
        vy_lim   = '0 - {2'b00, ctrl.max_speed};
        vy_above = $signed(vy_ext) > $signed(vy_lim);
        vy_diff  = vy_ext - {2'b00, ctrl.gstep};
        if (vy_diff[WORD_W:WORD_W-1] == 2'b10) begin
            vy_grav = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            vy_grav = vy_diff[WORD_W-1:0];
        end
        priority if (!ctrl.grav_on) begin
            vy_new = in_entry.vel_y;
        end else if (vy_above) begin
            vy_new = vy_grav;
        end else begin
            vy_new = vy_lim[WORD_W-1:0];
        end
        s2_valid_next     = in_valid && life_ok;
        s2_ent_next       = in_entry;
        s2_ent_next.life  = life_new;
        s2_ent_next.vel_y = vy_new;
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 2: survivor with new life and velocity
    always_ff @(posedge aclk) begin
        s2_ent_reg <= s2_ent_next;
    end

    // stage 3: velocity times delta time
    always_ff @(posedge aclk) begin
        s3_ent_reg <= s2_ent_reg;
        prod_x_reg <= $signed(s2_ent_reg.vel_x) * $signed({1'b0, ctrl.dt});
        prod_y_reg <= $signed(s2_ent_reg.vel_y) * $signed({1'b0, ctrl.dt});
        prod_z_reg <= $signed(s2_ent_reg.vel_z) * $signed({1'b0, ctrl.dt});
    end

    // write-back: saturating position update
    always_comb begin
        out_entry       = s3_ent_reg;
        out_entry.pos_x = add_sat(s3_ent_reg.pos_x, prod_x_reg);
        out_entry.pos_y = add_sat(s3_ent_reg.pos_y, prod_y_reg);
        out_entry.pos_z = add_sat(s3_ent_reg.pos_z, prod_z_reg);
        out_valid       = s3_valid_reg;
        busy            = s2_valid_reg || s3_valid_reg;
    end

endmodule

`default_nettype wire

[sim/particle_table_update_test.sv]
// self-checking bench for particle_table_update: spawn and tick beats in, survivor beats out
// keeps its own particle table model and checks every result beat; needs ptu_pkg and the rtl
`timescale 1ns / 1ps

module particle_table_update_test;
    import ptu_pkg::*;

    localparam int          DRAIN_CYCLES   = 150;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam longint      WORD_MAX       = 64'sd2147483647;
    localparam longint      WORD_MIN       = -64'sd2147483648;

    // one input beat
    typedef struct {
        logic                     action;
        logic [DT_W-1:0]          delta_time;
        logic signed [WORD_W-1:0] start_x, start_y, start_z;
        logic signed [WORD_W-1:0] speed_x, speed_y, speed_z;
        logic [LIFE_W-1:0]        lifetime;
        logic [WORD_W-1:0]        tint;
    } item_beat_t;

    // one particle of the table model
    typedef struct {
        logic [LIFE_W-1:0]        life;
        logic signed [WORD_W-1:0] vx, vy, vz;
        logic signed [WORD_W-1:0] px, py, pz;
        logic [WORD_W-1:0]        tint;
    } particle_entry_t;

    // one survivor beat
    typedef struct {
        logic signed [WORD_W-1:0] x, y, z;
        logic [WORD_W-1:0]        tint;
        logic                     last;
        logic [SURV_W-1:0]        count;
    } emitted_particle_t;

    logic                     aclk;
    logic                     aresetn      = 1'b0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic                     s_action     = ACT_SPAWN;
    logic [DT_W-1:0]          s_delta_time = '0;
    logic signed [WORD_W-1:0] s_start_x    = '0;
    logic signed [WORD_W-1:0] s_start_y    = '0;
    logic signed [WORD_W-1:0] s_start_z    = '0;
    logic signed [WORD_W-1:0] s_speed_x    = '0;
    logic signed [WORD_W-1:0] s_speed_y    = '0;
    logic signed [WORD_W-1:0] s_speed_z    = '0;
    logic [LIFE_W-1:0]        s_lifetime   = '0;
    logic [WORD_W-1:0]        s_tint       = '0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic signed [WORD_W-1:0] m_out_x;
    logic signed [WORD_W-1:0] m_out_y;
    logic signed [WORD_W-1:0] m_out_z;
    logic [WORD_W-1:0]        m_out_tint;
    logic                     m_final_res;
    logic [SURV_W-1:0]        m_survivors;
    logic                     cfg_we       = 1'b0;
    logic                     cfg_index    = REG_MAX_SPEED;
    logic [MS_W-1:0]          cfg_wdata    = '0;

    // table model and its copy of the registers
    particle_entry_t   particle_table [MAX_PARTICLES_DEF];
    int unsigned       table_count     = 0;
    logic [MS_W-1:0]   max_speed_cfg   = 31'd65536;
    logic              gravity_enabled = 1'b0;

    item_beat_t        pending_beats[$];
    emitted_particle_t expected_particles[$];
    item_beat_t        next_beat;
    item_beat_t        accepted_beat;
    emitted_particle_t oldest;
    logic              in_taken      = 1'b0;
    int unsigned       mismatches    = 0;
    int unsigned       stall_cycles  = 0;
    int unsigned       send_idle_pct = 6;
    int unsigned       recv_idle_pct = 86;
    logic              hold_request  = 1'b0;
    int unsigned       hold_left     = 0;

    particle_table_update dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_delta_time (s_delta_time),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_start_z    (s_start_z),
        .s_speed_x    (s_speed_x),
        .s_speed_y    (s_speed_y),
        .s_speed_z    (s_speed_z),
        .s_lifetime   (s_lifetime),
        .s_tint       (s_tint),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_out_z      (m_out_z),
        .m_out_tint   (m_out_tint),
        .m_final_res  (m_final_res),
        .m_survivors  (m_survivors),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // value times dt in q0.16, floored
    function automatic longint scaled_step(input longint v, input longint dt);
        return (v * dt) >>> 16;
    endfunction

    function automatic logic signed [WORD_W-1:0] clamp32(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX[WORD_W-1:0];
        if (v < WORD_MIN)
            return WORD_MIN[WORD_W-1:0];
        return WORD_W'(v);
    endfunction

    // apply one accepted beat to the table model, queue the survivors of a tick
    task automatic advance_table(input item_beat_t b);
        particle_entry_t   p;
        emitted_particle_t e;
        int                new_life;
        int unsigned       rd;
        int unsigned       wr;
        if (b.action == ACT_SPAWN) begin
            if (table_count < MAX_PARTICLES_DEF) begin
                p.life = b.lifetime;
                p.vx   = b.speed_x;
                p.vy   = b.speed_y;
                p.vz   = b.speed_z;
                p.px   = b.start_x;
                p.py   = b.start_y;
                p.pz   = b.start_z;
                p.tint = b.tint;
                particle_table[table_count] = p;
                table_count++;
            end
        end else begin
            wr = 0;
            for (rd = 0; rd < table_count; rd++) begin
                p = particle_table[rd];
                new_life = int'(p.life) - int'(b.delta_time);
                if (new_life > 0) begin
                    p.life = new_life[LIFE_W-1:0];
                    // gravity pulls vy down to the terminal speed
                    if (gravity_enabled) begin
                        if (longint'(p.vy) > -longint'(max_speed_cfg))
                            p.vy = clamp32(longint'(p.vy) -
                                           scaled_step(longint'(max_speed_cfg), b.delta_time));
                        else
                            p.vy = clamp32(-longint'(max_speed_cfg));
                    end
                    p.px = clamp32(longint'(p.px) + scaled_step(longint'(p.vx), b.delta_time));
                    p.py = clamp32(longint'(p.py) + scaled_step(longint'(p.vy), b.delta_time));
                    p.pz = clamp32(longint'(p.pz) + scaled_step(longint'(p.vz), b.delta_time));
                    particle_table[wr] = p;
                    wr++;
                end
            end
            table_count = wr;
            for (rd = 0; rd < wr; rd++) begin
                e.x     = particle_table[rd].px;
                e.y     = particle_table[rd].py;
                e.z     = particle_table[rd].pz;
                e.tint  = particle_table[rd].tint;
                e.last  = (rd + 1 == wr);
                e.count = SURV_W'(wr);
                expected_particles.push_back(e);
            end
        end
    endtask

    // stimulus builders
    function automatic item_beat_t spawn_beat(
        input logic signed [WORD_W-1:0] x, y, z, vx, vy, vz,
        input logic [LIFE_W-1:0] life, input logic [WORD_W-1:0] tint);
        item_beat_t b;
        b.action     = ACT_SPAWN;
        b.delta_time = DT_W'($urandom);
        b.start_x    = x;
        b.start_y    = y;
        b.start_z    = z;
        b.speed_x    = vx;
        b.speed_y    = vy;
        b.speed_z    = vz;
        b.lifetime   = life;
        b.tint       = tint;
        return b;
    endfunction

    function automatic item_beat_t tick_beat(input logic [DT_W-1:0] dt);
        item_beat_t b;
        b.action     = ACT_TICK;
        b.delta_time = dt;
        b.start_x    = $urandom;
        b.start_y    = $urandom;
        b.start_z    = $urandom;
        b.speed_x    = $urandom;
        b.speed_y    = $urandom;
        b.speed_z    = $urandom;
        b.lifetime   = LIFE_W'($urandom);
        b.tint       = $urandom;
        return b;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        logic signed [WORD_W-1:0] w;
        case ($urandom_range(4))
            0: w = $urandom;
            1: w = $signed($urandom) >>> $urandom_range(31, 4);
            2: w = 32'sh7FFF_FFFF;
            3: w = 32'sh8000_0000;
            default: w = $signed($urandom) >>> $urandom_range(20, 10);
        endcase
        return w;
    endfunction

    function automatic logic [LIFE_W-1:0] rand_life();
        logic [LIFE_W-1:0] l;
        case ($urandom_range(4))
            0: l = '0;
            1: l = LIFE_W'($urandom_range(24'h03_0000, 1));
            2: l = 24'hFF_FFFF;
            3: l = LIFE_W'($urandom) >> $urandom_range(12, 0);
            default: l = LIFE_W'($urandom_range(24'h08_0000, 24'h01_0000));
        endcase
        return l;
    endfunction

    function automatic logic [DT_W-1:0] rand_dt();
        logic [DT_W-1:0] d;
        case ($urandom_range(4))
            0: d = '0;
            1: d = 16'hFFFF;
            2: d = DT_W'($urandom);
            default: d = DT_W'($urandom_range(16'h2000, 1));
        endcase
        return d;
    endfunction

    function automatic item_beat_t rand_spawn();
        return spawn_beat(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_life(), $urandom);
    endfunction

    function automatic item_beat_t noise_beat();
        item_beat_t b;
        b = tick_beat(DT_W'($urandom));
        b.action = $urandom_range(1);
        return b;
    endfunction

    // mostly spawn bursts closed by a tick, some noise beats
    task automatic queue_random(input int unsigned n);
        int unsigned queued;
        int unsigned burst;
        queued = 0;
        while (queued < n) begin
            case ($urandom_range(9))
                7: burst = $urandom_range(40, 8);
                8, 9: burst = 0;
                default: burst = $urandom_range(6, 1);
            endcase
            if (burst == 0) begin
                pending_beats.push_back(noise_beat());
                queued++;
            end else begin
                repeat (burst) pending_beats.push_back(rand_spawn());
                pending_beats.push_back(tick_beat(rand_dt()));
                queued += burst + 1;
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [MS_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_MAX_SPEED)
            max_speed_cfg = val;
        else
            gravity_enabled = val[0];
    endtask

    // wait until every beat is sent, every survivor seen and the block has settled
    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid) @(posedge aclk);
        while (expected_particles.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // input driver
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !in_taken)) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat = pending_beats.pop_front();
                s_valid      <= 1'b1;
                s_action     <= next_beat.action;
                s_delta_time <= next_beat.delta_time;
                s_start_x    <= next_beat.start_x;
                s_start_y    <= next_beat.start_y;
                s_start_z    <= next_beat.start_z;
                s_speed_x    <= next_beat.speed_x;
                s_speed_y    <= next_beat.speed_y;
                s_speed_z    <= next_beat.speed_z;
                s_lifetime   <= next_beat.lifetime;
                s_tint       <= next_beat.tint;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: check result beats, feed accepted input beats to the model
    always @(posedge aclk) begin
        in_taken = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_particles.size() == 0) begin
                    $error("result beat with no particle expected");
                    mismatches++;
                end else begin
                    oldest = expected_particles.pop_front();
                    if (m_out_x !== oldest.x) begin
                        $error("out_x expected %0d got %0d", oldest.x, m_out_x);
                        mismatches++;
                    end
                    if (m_out_y !== oldest.y) begin
                        $error("out_y expected %0d got %0d", oldest.y, m_out_y);
                        mismatches++;
                    end
                    if (m_out_z !== oldest.z) begin
                        $error("out_z expected %0d got %0d", oldest.z, m_out_z);
                        mismatches++;
                    end
                    if (m_out_tint !== oldest.tint) begin
                        $error("out_tint expected %h got %h", oldest.tint, m_out_tint);
                        mismatches++;
                    end
                    if (m_final_res !== oldest.last) begin
                        $error("final_res expected %0d got %0d", oldest.last, m_final_res);
                        mismatches++;
                    end
                    if (m_survivors !== oldest.count) begin
                        $error("survivors expected %0d got %0d", oldest.count, m_survivors);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                in_taken = 1'b1;
                accepted_beat.action     = s_action;
                accepted_beat.delta_time = s_delta_time;
                accepted_beat.start_x    = s_start_x;
                accepted_beat.start_y    = s_start_y;
                accepted_beat.start_z    = s_start_z;
                accepted_beat.speed_x    = s_speed_x;
                accepted_beat.speed_y    = s_speed_y;
                accepted_beat.speed_z    = s_speed_z;
                accepted_beat.lifetime   = s_lifetime;
                accepted_beat.tint       = s_tint;
                advance_table(accepted_beat);
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // sequence of phases
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed beats on the reset settings
        pending_beats.push_back(tick_beat(16'hFFFF));
        // zero lifetime particle is gone after the next tick, even a zero-length one
        pending_beats.push_back(spawn_beat('0, '0, '0, '0, '0, '0, '0, '0));
        pending_beats.push_back(tick_beat('0));
        // positions saturating both ways
        pending_beats.push_back(spawn_beat(32'sh7FFF_FFFF, 32'sh8000_0000, '0, 32'sh7FFF_FFFF,
                                           32'sh8000_0000, '1, 24'hFF_FFFF, '1));
        pending_beats.push_back(spawn_beat(32'sh8000_0000, 32'sh7FFF_FFFF, '1, 32'sh8000_0000,
                                           32'sh7FFF_FFFF, 1, 24'h00_0001, 32'hA5A5_5A5A));
        pending_beats.push_back(spawn_beat(-65536, 65536, 12345, -3, 3, -1, 24'h00_0002,
                                           32'h1234_5678));
        pending_beats.push_back(spawn_beat(0, 0, 0, 65536, -65536, 1, 24'h01_0000,
                                           32'h0F0F_F0F0));
        // lives reaching exactly zero are removed
        pending_beats.push_back(tick_beat(16'h0001));
        pending_beats.push_back(tick_beat(16'hFFFF));
        pending_beats.push_back(tick_beat(16'h0000));
        repeat (6) pending_beats.push_back(rand_spawn());
        pending_beats.push_back(tick_beat(16'h8000));
        pending_beats.push_back(tick_beat(16'h0001));
        pending_beats.push_back(tick_beat(rand_dt()));
        wait_drained();

        // gravity with zero terminal speed
        write_reg(REG_MAX_SPEED, '0);
        write_reg(REG_GRAVITY_ON, 31'd1);
        queue_random(55);
        wait_drained();

        // sender idles more, largest terminal speed, gravity from a wide odd value
        send_idle_pct = 86;
        recv_idle_pct = 6;
        write_reg(REG_MAX_SPEED, 31'h7FFF_FFFF);
        write_reg(REG_GRAVITY_ON, MS_W'($urandom) | 31'd1);
        queue_random(55);
        wait_drained();

        // gravity off from a wide even value
        write_reg(REG_MAX_SPEED, MS_W'($urandom_range(32'h0004_0000, 1)));
        write_reg(REG_GRAVITY_ON, MS_W'($urandom) & ~31'd1);
        queue_random(55);
        wait_drained();

        // no idling; fill the table and hold the receiver so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MAX_SPEED, 31'd65536);
        write_reg(REG_GRAVITY_ON, 31'd1);
        repeat (66) pending_beats.push_back(spawn_beat(rand_word(), rand_word(), rand_word(),
                                                       rand_word(), rand_word(), rand_word(),
                                                       24'hFF_FFFF, $urandom));
        repeat (4) pending_beats.push_back(tick_beat(rand_dt()));
        hold_request = 1'b1;
        wait_drained();

        // random registers
        write_reg(REG_MAX_SPEED, MS_W'($urandom));
        write_reg(REG_GRAVITY_ON, MS_W'($urandom));
        queue_random(55);
        wait_drained();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
